// ===== rtl/core/rhp_pkg.sv =====
// Shared types and constants of the RTP header parser.
// No dependencies; used by every module of the block except rhp_fifo.
package rhp_pkg;

    localparam logic [3:0] FIXED_BYTES = 4'd12;
    localparam logic [3:0] WORD_BYTES  = 4'd4;
    localparam int         HDR_CNT_W   = 19;

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_CSRC,
        PH_EXTHEAD,
        PH_EXTWORD,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [2:0] {
        KIND_FIXED   = 3'd0,
        KIND_CSRC    = 3'd1,
        KIND_EXTHEAD = 3'd2,
        KIND_EXTWORD = 3'd3,
        KIND_DONE    = 3'd4,
        KIND_TRUNC   = 3'd5
    } t_kind;

    // All results caused by one byte: a first result and an optional second.
    typedef struct packed {
        t_kind       kind_a;
        logic [31:0] word_a;
        logic [31:0] fixed0;
        logic [31:0] fixed1;
        logic [31:0] fixed2;
        logic        has_b;
        t_kind       kind_b;
        logic [31:0] word_b;
    } t_entry;

endpackage

// ===== rtl/core/rhp_front.sv =====
// Front end: accepts packet bytes, tracks the header phase and packs the
// results of each byte into one queue entry. Depends on rhp_pkg.
module rhp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_packet,
    output logic            o_wr,
    output rhp_pkg::t_entry o_entry
);
    import rhp_pkg::*;

    t_phase                 r_phase, n_phase, w_phase_after;
    logic [3:0]             r_pos, n_pos;
    logic [31:0]            r_ws, n_ws;
    logic [31:0]            r_f0, n_f0, r_f1, n_f1, r_f2, n_f2;
    logic [3:0]             r_csrc, n_csrc;
    logic [15:0]            r_ext, n_ext;
    logic [HDR_CNT_W-1:0]   r_hb, n_hb;

    logic [3:0]             w_pos_clamp, w_pos_inc, w_wpos_inc;
    logic [1:0]             w_fix_sel;
    logic                   w_fixed_done, w_word_done, w_first, w_done, w_trunc;
    logic [31:0]            w_ws_next, w_f0_new, w_f1_new, w_f2_new;
    logic [HDR_CNT_W-1:0]   w_hb_next;

    assign w_pos_clamp  = (r_pos >= FIXED_BYTES) ? (FIXED_BYTES - 4'd1) : r_pos;
    assign w_fix_sel    = w_pos_clamp[3:2];
    assign w_pos_inc    = w_pos_clamp + 4'd1;
    assign w_wpos_inc   = r_pos + 4'd1;
    assign w_fixed_done = (r_phase == PH_FIXED) && (w_pos_inc == FIXED_BYTES);
    assign w_word_done  = (w_wpos_inc >= WORD_BYTES);
    assign w_ws_next    = {r_ws[23:0], i_data_byte};
    assign w_hb_next    = r_hb + {{(HDR_CNT_W-1){1'b0}}, 1'b1};
    assign w_f0_new     = (w_fix_sel == 2'd0) ? {r_f0[23:0], i_data_byte} : r_f0;
    assign w_f1_new     = (w_fix_sel == 2'd1) ? {r_f1[23:0], i_data_byte} : r_f1;
    assign w_f2_new     = (w_fix_sel == 2'd2) ? {r_f2[23:0], i_data_byte} : r_f2;

    // Phase after this byte, before end of packet is applied.
    always_comb begin
        w_phase_after = r_phase;
        case (r_phase)
            PH_FIXED: begin
                if (w_fixed_done) begin
                    if (w_f0_new[27:24] != 4'd0) w_phase_after = PH_CSRC;
                    else if (w_f0_new[28])       w_phase_after = PH_EXTHEAD;
                    else                         w_phase_after = PH_PAYLOAD;
                end
            end
            PH_CSRC: begin
                if (w_word_done && r_csrc == 4'd1)
                    w_phase_after = r_f0[28] ? PH_EXTHEAD : PH_PAYLOAD;
            end
            PH_EXTHEAD: begin
                if (w_word_done)
                    w_phase_after = (w_ws_next[15:0] == 16'd0) ? PH_PAYLOAD : PH_EXTWORD;
            end
            PH_EXTWORD: begin
                if (w_word_done && r_ext == 16'd1) w_phase_after = PH_PAYLOAD;
            end
            PH_PAYLOAD: w_phase_after = PH_PAYLOAD;
            default:    w_phase_after = PH_PAYLOAD;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            n_phase = i_end_of_packet ? PH_FIXED : w_phase_after;
        end
    end

    assign w_first = w_fixed_done ||
                     (w_word_done && (r_phase == PH_CSRC || r_phase == PH_EXTHEAD ||
                                      r_phase == PH_EXTWORD));
    assign w_done  = (r_phase != PH_PAYLOAD) && (w_phase_after == PH_PAYLOAD);
    assign w_trunc = i_end_of_packet && (w_phase_after != PH_PAYLOAD);

    // Results of the byte.
    always_comb begin
        o_entry        = '0;
        o_entry.fixed0 = w_f0_new;
        o_entry.fixed1 = w_f1_new;
        o_entry.fixed2 = w_f2_new;
        o_entry.word_b = {{(32-HDR_CNT_W){1'b0}}, w_hb_next};
        o_entry.kind_b = w_done ? KIND_DONE : KIND_TRUNC;
        if (w_first) begin
            o_entry.has_b = w_done || w_trunc;
            o_entry.word_a = w_ws_next;
            case (r_phase)
                PH_FIXED: begin
                    o_entry.kind_a = KIND_FIXED;
                    o_entry.word_a = '0;
                end
                PH_CSRC:    o_entry.kind_a = KIND_CSRC;
                PH_EXTHEAD: o_entry.kind_a = KIND_EXTHEAD;
                default:    o_entry.kind_a = KIND_EXTWORD;
            endcase
        end else begin
            o_entry.kind_a = KIND_TRUNC;
            o_entry.word_a = {{(32-HDR_CNT_W){1'b0}}, w_hb_next};
            o_entry.has_b  = 1'b0;
        end
    end

    assign o_wr = i_accept && (w_first || w_trunc);

    // Datapath next values.
    always_comb begin
        n_pos  = r_pos;
        n_ws   = r_ws;
        n_f0   = r_f0;
        n_f1   = r_f1;
        n_f2   = r_f2;
        n_csrc = r_csrc;
        n_ext  = r_ext;
        n_hb   = r_hb;
        if (i_accept) begin
            if (i_end_of_packet) begin
                n_pos  = '0;
                n_ws   = '0;
                n_f0   = '0;
                n_f1   = '0;
                n_f2   = '0;
                n_csrc = '0;
                n_ext  = '0;
                n_hb   = '0;
            end else begin
                case (r_phase)
                    PH_FIXED: begin
                        n_f0 = w_f0_new;
                        n_f1 = w_f1_new;
                        n_f2 = w_f2_new;
                        n_hb = w_hb_next;
                        n_pos = w_pos_inc;
                        if (w_fixed_done) begin
                            n_pos  = '0;
                            n_ws   = '0;
                            n_csrc = w_f0_new[27:24];
                        end
                    end
                    PH_CSRC, PH_EXTHEAD, PH_EXTWORD: begin
                        n_ws  = w_ws_next;
                        n_hb  = w_hb_next;
                        n_pos = w_word_done ? 4'd0 : w_wpos_inc;
                        if (w_word_done) begin
                            if (r_phase == PH_CSRC)    n_csrc = r_csrc - 4'd1;
                            if (r_phase == PH_EXTHEAD) n_ext  = w_ws_next[15:0];
                            if (r_phase == PH_EXTWORD) n_ext  = r_ext - 16'd1;
                        end
                    end
                    default: begin
                        n_pos = r_pos;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIXED;
            r_pos   <= '0;
            r_ws    <= '0;
            r_f0    <= '0;
            r_f1    <= '0;
            r_f2    <= '0;
            r_csrc  <= '0;
            r_ext   <= '0;
            r_hb    <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_ws    <= n_ws;
            r_f0    <= n_f0;
            r_f1    <= n_f1;
            r_f2    <= n_f2;
            r_csrc  <= n_csrc;
            r_ext   <= n_ext;
            r_hb    <= n_hb;
        end
    end

endmodule

// ===== rtl/core/rhp_fifo.sv =====
// Short register queue between front and back end.
// Generic in width and depth; no package dependency.
module rhp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr, r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) n_wptr = (r_wptr == LAST) ? '0 : r_wptr + AW'(1);
        if (w_rd) n_rptr = (r_rptr == LAST) ? '0 : r_rptr + AW'(1);
        if (w_wr && !w_rd) n_cnt = r_cnt + CW'(1);
        else if (w_rd && !w_wr) n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wptr] <= i_wdata;
    end

endmodule

// ===== rtl/core/rhp_back.sv =====
// Back end: holds one queue entry in the output register and presents its
// results one per transaction. Depends on rhp_pkg.
module rhp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rhp_pkg::t_entry    i_entry,
    input  logic               i_avail,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_valid,
    output rhp_pkg::t_kind     o_kind,
    output logic [1:0]         o_version,
    output logic               o_padding_flag,
    output logic               o_extension_flag,
    output logic [3:0]         o_csrc_count,
    output logic               o_marker,
    output logic [6:0]         o_media_type,
    output logic [15:0]        o_sequence_number,
    output logic [31:0]        o_timestamp,
    output logic [31:0]        o_source_id,
    output logic [31:0]        o_word,
    output logic               o_last_of_run
);
    import rhp_pkg::*;

    t_entry r_ent;
    logic   r_valid, n_valid;
    logic   r_second, n_second;
    logic   w_show_fixed;

    // Advance to the second result, or reload from the queue.
    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        o_take   = 1'b0;
        if (!r_valid || i_pop) begin
            if (r_valid && !r_second && r_ent.has_b) begin
                n_second = 1'b1;
            end else begin
                o_take   = i_avail;
                n_valid  = i_avail;
                n_second = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_ent <= i_entry;
    end

    assign w_show_fixed = !r_second && (r_ent.kind_a == KIND_FIXED);

    always_comb begin
        o_valid           = r_valid;
        o_kind            = r_second ? r_ent.kind_b : r_ent.kind_a;
        o_word            = r_second ? r_ent.word_b : r_ent.word_a;
        o_last_of_run     = r_second || !r_ent.has_b;
        o_version         = '0;
        o_padding_flag    = 1'b0;
        o_extension_flag  = 1'b0;
        o_csrc_count      = '0;
        o_marker          = 1'b0;
        o_media_type      = '0;
        o_sequence_number = '0;
        o_timestamp       = '0;
        o_source_id       = '0;
        if (w_show_fixed) begin
            o_version         = r_ent.fixed0[31:30];
            o_padding_flag    = r_ent.fixed0[29];
            o_extension_flag  = r_ent.fixed0[28];
            o_csrc_count      = r_ent.fixed0[27:24];
            o_marker          = r_ent.fixed0[23];
            o_media_type      = r_ent.fixed0[22:16];
            o_sequence_number = r_ent.fixed0[15:0];
            o_timestamp       = r_ent.fixed1;
            o_source_id       = r_ent.fixed2;
        end
    end

endmodule

// ===== rtl/core/rtp_header_parser.sv =====
// RTP header parser (RFC 3550 fixed header, CSRC list, header extension).
// Depends on rhp_pkg, rhp_front, rhp_fifo and rhp_back.
//
// Packet bytes are pushed one per cycle; a byte is taken whenever full is
// low, so the input runs at one byte per cycle as long as the results are
// popped. Each byte gives zero, one or two results; the front end packs
// them into one entry of a QUEUE_DEPTH-entry queue, and the back end's
// output register hands them out at one result per cycle while results
// are popped. A result passes through the queue, then the output register.
// The output side sets the sustained rate: a byte with two results (a
// word completed on the byte that closes the header or ends a short
// packet) needs one pop for each result.
// Extension length counts 32-bit words; the done and truncated results
// carry the header bytes seen so far. No clearing pass after reset.
module rtp_header_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_version,
    output logic        o_padding_flag,
    output logic        o_extension_flag,
    output logic [3:0]  o_csrc_count,
    output logic        o_marker,
    output logic [6:0]  o_media_type,
    output logic [15:0] o_sequence_number,
    output logic [31:0] o_timestamp,
    output logic [31:0] o_source_id,
    output logic [31:0] o_word,
    output logic        o_last_of_run
);
    import rhp_pkg::*;

    localparam int EW = $bits(t_entry);

    t_entry  w_front_entry, w_queue_entry;
    logic    w_accept, w_wr, w_take, w_q_empty, w_valid;
    t_kind   w_kind;

    assign w_accept = push && !full;

    rhp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_wr            (w_wr),
        .o_entry         (w_front_entry)
    );

    rhp_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_front_entry),
        .i_rd    (w_take),
        .o_rdata (w_queue_entry),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    rhp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_entry           (w_queue_entry),
        .i_avail           (!w_q_empty),
        .o_take            (w_take),
        .i_pop             (pop),
        .o_valid           (w_valid),
        .o_kind            (w_kind),
        .o_version         (o_version),
        .o_padding_flag    (o_padding_flag),
        .o_extension_flag  (o_extension_flag),
        .o_csrc_count      (o_csrc_count),
        .o_marker          (o_marker),
        .o_media_type      (o_media_type),
        .o_sequence_number (o_sequence_number),
        .o_timestamp       (o_timestamp),
        .o_source_id       (o_source_id),
        .o_word            (o_word),
        .o_last_of_run     (o_last_of_run)
    );

    assign empty  = !w_valid;
    assign o_kind = w_kind;

    // A result that is not last of its run is followed at once by another.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_of_run) |=> !empty)
        else $error("second result of a run missing");

    // The second result of a run is always done or truncated.
    a_second_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_of_run) |=>
            (o_kind == KIND_DONE || o_kind == KIND_TRUNC))
        else $error("second result of a run has wrong kind");

    // Header fields are zero outside the fixed header result.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != KIND_FIXED) |->
            (o_version == 2'd0 && o_timestamp == 32'd0 && o_source_id == 32'd0))
        else $error("header fields set on non-header result");

endmodule

// ===== tb/sv/rtp_header_parser_tb.sv =====
`timescale 1ns / 100ps
// Testbench for rtp_header_parser: feeds RTP packets byte by byte and checks
// every header result against a local parser model. Depends on rhp_pkg.
module rtp_header_parser_tb;

    import rhp_pkg::*;

    localparam int CLK_HALF_NS = 6;
    localparam int TIMEOUT_NS  = 1_200_000;
    localparam int IDLE_PCT    = 8;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        t_kind       kind;
        logic [1:0]  version;
        logic        padding_flag;
        logic        extension_flag;
        logic [3:0]  csrc_count;
        logic        marker;
        logic [6:0]  media_type;
        logic [15:0] sequence_number;
        logic [31:0] timestamp;
        logic [31:0] source_id;
        logic [31:0] word;
        logic        last_of_run;
    } t_hdr_result;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        push            = 1'b0;
    logic [7:0]  i_data_byte     = 8'd0;
    logic        i_end_of_packet = 1'b0;
    logic        pop             = 1'b0;
    logic        full;
    logic        empty;
    logic [2:0]  o_kind;
    logic [1:0]  o_version;
    logic        o_padding_flag;
    logic        o_extension_flag;
    logic [3:0]  o_csrc_count;
    logic        o_marker;
    logic [6:0]  o_media_type;
    logic [15:0] o_sequence_number;
    logic [31:0] o_timestamp;
    logic [31:0] o_source_id;
    logic [31:0] o_word;
    logic        o_last_of_run;

    // Parser model state
    t_phase                 parse_phase = PH_FIXED;
    logic [3:0]             pos_cnt     = '0;
    logic [31:0]            shift_word  = '0;
    logic [31:0]            fixed_words [3] = '{default: '0};
    logic [3:0]             csrc_todo   = '0;
    logic [15:0]            ext_todo    = '0;
    logic [HDR_CNT_W-1:0]   hdr_count   = '0;

    t_hdr_result pending_results [$];
    t_hdr_result step_results [$];
    logic [7:0]  pkt_bytes [$];
    int          error_count = 0;
    int          bytes_sent  = 0;
    bit          quiet       = 1'b0;

    rtp_header_parser DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_data_byte       (i_data_byte),
        .i_end_of_packet   (i_end_of_packet),
        .empty             (empty),
        .pop               (pop),
        .o_kind            (o_kind),
        .o_version         (o_version),
        .o_padding_flag    (o_padding_flag),
        .o_extension_flag  (o_extension_flag),
        .o_csrc_count      (o_csrc_count),
        .o_marker          (o_marker),
        .o_media_type      (o_media_type),
        .o_sequence_number (o_sequence_number),
        .o_timestamp       (o_timestamp),
        .o_source_id       (o_source_id),
        .o_word            (o_word),
        .o_last_of_run     (o_last_of_run)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic t_hdr_result make_result(input t_kind k, input logic [31:0] w);
        t_hdr_result r;
        r = '{kind: k, word: w, default: '0};
        return r;
    endfunction

    task automatic clear_parse();
        parse_phase = PH_FIXED;
        pos_cnt     = '0;
        shift_word  = '0;
        fixed_words = '{default: '0};
        csrc_todo   = '0;
        ext_todo    = '0;
        hdr_count   = '0;
    endtask

    task automatic close_header();
        step_results.insert(step_results.size(), make_result(KIND_DONE, 32'(hdr_count)));
        parse_phase = PH_PAYLOAD;
    endtask

    // Advance the parser model by one accepted byte and queue its results.
    task automatic predict_byte(input logic [7:0] b, input logic eop);
        t_hdr_result r;
        logic        ext_on;
        logic        word_done;
        step_results.delete();
        ext_on    = fixed_words[0][28];
        word_done = 1'b0;
        if (parse_phase inside {PH_CSRC, PH_EXTHEAD, PH_EXTWORD}) begin
            shift_word = {shift_word[23:0], b};
            hdr_count  = hdr_count + 1'b1;
            pos_cnt    = pos_cnt + 1'b1;
            if (pos_cnt >= WORD_BYTES) begin
                pos_cnt   = '0;
                word_done = 1'b1;
            end
        end
        case (parse_phase)
            PH_FIXED: begin
                fixed_words[pos_cnt[3:2]] = {fixed_words[pos_cnt[3:2]][23:0], b};
                hdr_count = hdr_count + 1'b1;
                pos_cnt   = pos_cnt + 1'b1;
                if (pos_cnt == FIXED_BYTES) begin
                    r = make_result(KIND_FIXED, 32'd0);
                    r.version         = fixed_words[0][31:30];
                    r.padding_flag    = fixed_words[0][29];
                    r.extension_flag  = fixed_words[0][28];
                    r.csrc_count      = fixed_words[0][27:24];
                    r.marker          = fixed_words[0][23];
                    r.media_type      = fixed_words[0][22:16];
                    r.sequence_number = fixed_words[0][15:0];
                    r.timestamp       = fixed_words[1];
                    r.source_id       = fixed_words[2];
                    step_results.insert(step_results.size(), r);
                    pos_cnt    = '0;
                    shift_word = '0;
                    ext_on     = fixed_words[0][28];
                    csrc_todo  = fixed_words[0][27:24];
                    if (csrc_todo != 0)
                        parse_phase = PH_CSRC;
                    else if (ext_on)
                        parse_phase = PH_EXTHEAD;
                    else
                        close_header();
                end
            end
            PH_CSRC: begin
                if (word_done) begin
                    step_results.insert(step_results.size(),
                                        make_result(KIND_CSRC, shift_word));
                    csrc_todo = csrc_todo - 1'b1;
                    if (csrc_todo == 0) begin
                        if (ext_on)
                            parse_phase = PH_EXTHEAD;
                        else
                            close_header();
                    end
                end
            end
            PH_EXTHEAD: begin
                if (word_done) begin
                    step_results.insert(step_results.size(),
                                        make_result(KIND_EXTHEAD, shift_word));
                    ext_todo = shift_word[15:0];
                    if (ext_todo == 0)
                        close_header();
                    else
                        parse_phase = PH_EXTWORD;
                end
            end
            PH_EXTWORD: begin
                if (word_done) begin
                    step_results.insert(step_results.size(),
                                        make_result(KIND_EXTWORD, shift_word));
                    ext_todo = ext_todo - 1'b1;
                    if (ext_todo == 0)
                        close_header();
                end
            end
            default: parse_phase = PH_PAYLOAD;
        endcase
        if (eop) begin
            if (parse_phase != PH_PAYLOAD)
                step_results.insert(step_results.size(),
                                    make_result(KIND_TRUNC, 32'(hdr_count)));
            clear_parse();
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        foreach (step_results[i])
            pending_results.insert(pending_results.size(), step_results[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s: got %0h, want %0h", name, got, want));
    endtask

    task automatic check_result(input t_hdr_result want);
        check_field("kind",            32'(o_kind),            32'(want.kind));
        check_field("version",         32'(o_version),         32'(want.version));
        check_field("padding_flag",    32'(o_padding_flag),    32'(want.padding_flag));
        check_field("extension_flag",  32'(o_extension_flag),  32'(want.extension_flag));
        check_field("csrc_count",      32'(o_csrc_count),      32'(want.csrc_count));
        check_field("marker",          32'(o_marker),          32'(want.marker));
        check_field("media_type",      32'(o_media_type),      32'(want.media_type));
        check_field("sequence_number", 32'(o_sequence_number), 32'(want.sequence_number));
        check_field("timestamp",       o_timestamp,            want.timestamp);
        check_field("source_id",       o_source_id,            want.source_id);
        check_field("word",            o_word,                 want.word);
        check_field("last_of_run",     32'(o_last_of_run),     32'(want.last_of_run));
    endtask

    // Sample both handshakes on the edge; predict first, then check.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                predict_byte(i_data_byte, i_end_of_packet);
            if (pop && !empty) begin
                if (pending_results.size() == 0)
                    report_error($sformatf("unexpected result, kind %0d", o_kind));
                else
                    check_result(pending_results.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Caller sits on a rising edge; returns on the edge that takes the byte.
    task automatic send_byte(input logic [7:0] b, input logic eop);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_data_byte     <= b;
        i_end_of_packet <= eop;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt_bytes[i])
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    task automatic append_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            pkt_bytes.insert(pkt_bytes.size(), w[8*i +: 8]);
    endtask

    // Build a well-formed packet; wild_ext puts any value in the extension
    // length field but appends at most a few extension words.
    task automatic build_packet(input int csrc_max, input bit wild_ext, input int payload_max);
        logic [31:0] w;
        int          cc;
        int          xlen;
        logic        xb;
        cc   = $urandom_range(csrc_max);
        xb   = 1'($urandom_range(1));
        xlen = wild_ext ? $urandom_range(16'hFFFF) : $urandom_range(3);
        pkt_bytes.delete();
        w = $urandom;
        w[27:24] = 4'(cc);
        w[28]    = xb;
        append_word(w);
        append_word($urandom);
        append_word($urandom);
        repeat (cc)
            append_word($urandom);
        if (xb) begin
            w = $urandom;
            w[15:0] = 16'(xlen);
            append_word(w);
            repeat (xlen > 3 ? 3 : xlen)
                append_word($urandom);
        end
        repeat ($urandom_range(payload_max))
            pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
    endtask

    task automatic test_directed_headers();
        // All-ones fields apart from padding, no CSRC, no extension; ends right at header end.
        pkt_bytes = '{8'hC0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet();
        // Zero fields, one CSRC, extension of zero length ending the packet.
        pkt_bytes.delete();
        append_word(32'h3100_0000);
        append_word(32'h0000_0000);
        append_word(32'h0000_0000);
        append_word(32'hDEAD_BEEF);
        append_word(32'hFFFF_0000);
        send_packet();
        // Packet ending on its first byte.
        pkt_bytes = '{8'hA5};
        send_packet();
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int stop_at;
        int pick;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                build_packet(($urandom_range(9) == 0) ? 15 : 3, 1'b0, 6);
                send_packet();
            end else if (pick < 92) begin
                // Cut a packet short somewhere inside or past its header.
                build_packet(($urandom_range(3) == 0) ? 15 : 2, 1'b1, 2);
                while (pkt_bytes.size() > 1 && $urandom_range(3) != 0)
                    pkt_bytes.pop_back();
                send_packet();
            end else begin
                repeat ($urandom_range(1, 5))
                    send_byte(8'($urandom), $urandom_range(4) == 0);
                send_byte(8'($urandom), 1'b1);
            end
        end
    endtask

    task automatic test_drain_pause();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_burst_no_idle(input int n_bytes);
        quiet = 1'b1;
        test_random_traffic(n_bytes);
        quiet = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_headers();
        test_random_traffic(150);
        test_drain_pause();
        test_burst_no_idle(110);
        test_random_traffic(120);

        push <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("tb: failure");
        $finish;
    end

endmodule
